// ----- hw/rtl/piqf_pkg.sv -----
package piqf_pkg;

    localparam int CFG_INDEX_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LEFT_X     = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LEFT_Y     = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM_LEFT_X  = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM_LEFT_Y  = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM_RIGHT_X = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM_RIGHT_Y = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_RIGHT_X    = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_RIGHT_Y    = 4'd7;

    localparam int NUM_CORNER_REGS = 8;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_edge_sign;

    typedef struct packed {
        logic valid;
        logic keep;
        logic last;
    } t_flags;

endpackage

// ----- hw/rtl/piqf_cfg_regs.sv -----
module piqf_cfg_regs
    import piqf_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [CFG_INDEX_BITS-1:0]    i_index,
    input  logic [COORD_BITS-1:0]        i_data,
    output logic signed [COORD_BITS-1:0] o_corner [NUM_CORNER_REGS]
);

    logic signed [COORD_BITS-1:0] r_corner [NUM_CORNER_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CORNER_REGS; k++) begin
                r_corner[k] <= '0;
            end
        end else if (i_we) begin
            case (i_index)
                REG_TOP_LEFT_X:     r_corner[0] <= i_data;
                REG_TOP_LEFT_Y:     r_corner[1] <= i_data;
                REG_BOTTOM_LEFT_X:  r_corner[2] <= i_data;
                REG_BOTTOM_LEFT_Y:  r_corner[3] <= i_data;
                REG_BOTTOM_RIGHT_X: r_corner[4] <= i_data;
                REG_BOTTOM_RIGHT_Y: r_corner[5] <= i_data;
                REG_TOP_RIGHT_X:    r_corner[6] <= i_data;
                REG_TOP_RIGHT_Y:    r_corner[7] <= i_data;
                default: ;
            endcase
        end
    end

    assign o_corner = r_corner;

endmodule

// ----- hw/rtl/piqf_edge_eval.sv -----
module piqf_edge_eval
    import piqf_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_ex,
    input  logic signed [COORD_BITS-1:0] i_ey,
    input  logic signed [COORD_BITS-1:0] i_fx,
    input  logic signed [COORD_BITS-1:0] i_fy,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output t_edge_sign                   o_sign
);

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;
    localparam int W = P + 1;

    logic signed [D-1:0] a;
    logic signed [D-1:0] b;
    logic signed [D-1:0] c;
    logic signed [D-1:0] d;
    logic signed [P-1:0] r_p;
    logic signed [P-1:0] r_q;
    logic signed [W-1:0] diff;
    t_edge_sign          r_sign;

    assign a = D'(i_fy) - D'(i_ey);
    assign b = D'(i_px) - D'(i_ex);
    assign c = D'(i_fx) - D'(i_ex);
    assign d = D'(i_py) - D'(i_ey);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= a * b;
            r_q <= c * d;
        end
    end

    assign diff = W'(r_p) - W'(r_q);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sign.neg  <= diff[W-1];
            r_sign.zero <= (diff == '0);
        end
    end

    assign o_sign = r_sign;

endmodule

// ----- hw/rtl/piqf_count.sv -----
module piqf_count
    import piqf_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_flags                i_flags,
    input  t_edge_sign            i_top,
    input  t_edge_sign            i_bottom,
    input  t_edge_sign            i_left,
    input  t_edge_sign            i_right,
    output logic                  o_valid,
    output logic                  o_keep,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_last
);

    logic                  r_o_valid;
    logic                  r_o_keep;
    logic [COUNT_BITS-1:0] r_o_count;
    logic                  r_o_last;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] n_total;
    logic                  same_tb;
    logic                  same_lr;
    logic                  kept;

    // Two opposite edges reject the point only when both are nonzero with equal sign.
    assign same_tb = !i_top.zero && !i_bottom.zero && (i_top.neg == i_bottom.neg);
    assign same_lr = !i_left.zero && !i_right.zero && (i_left.neg == i_right.neg);
    assign kept    = i_flags.keep && !same_tb && !same_lr;

    always_comb begin
        n_total = r_total;
        if (kept && (r_total != {COUNT_BITS{1'b1}})) begin
            n_total = r_total + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_total   <= '0;
        end else if (i_en) begin
            r_o_valid <= i_flags.valid;
            if (i_flags.valid) begin
                r_total <= i_flags.last ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_flags.valid) begin
            r_o_keep  <= kept;
            r_o_count <= n_total;
            r_o_last  <= i_flags.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_keep  = r_o_keep;
    assign o_count = r_o_count;
    assign o_last  = r_o_last;

    a_keep_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_keep |-> r_o_count != '0)
        else $error("kept word shows a zero count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_flags.valid && i_flags.last |=> r_total == '0)
        else $error("count not cleared after batch end");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_flags.valid && !i_flags.last && !kept |=> $stable(r_total))
        else $error("count moved on a rejected word");

endmodule

// ----- hw/rtl/point_in_quad_filter_core.sv -----
// Channel  Direction  Handshake              Payload
// input    in         i_valid / o_stall      i_point_x, i_point_y, i_keep_in, i_last
// output   out        o_valid / i_stall      o_keep_out, o_inside_count, o_last_out
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word is accepted per cycle unless a held result stalls the pipeline.
// The four stages are the input register, the edge product registers, the edge
// sign registers and the result register with the batch counter.
// The whole pipeline advances together and halts only while a result is held by a stall.
// Reset clears the corners, the running count and all valid flags.
module point_in_quad_filter_core
    import piqf_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [COORD_BITS-1:0]     i_point_x,
    input  logic [COORD_BITS-1:0]     i_point_y,
    input  logic                      i_keep_in,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_keep_out,
    output logic [COUNT_BITS-1:0]     o_inside_count,
    output logic                      o_last_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]     i_cfg_data
);

    logic signed [COORD_BITS-1:0] corner [NUM_CORNER_REGS];
    logic signed [COORD_BITS-1:0] r_s0_px;
    logic signed [COORD_BITS-1:0] r_s0_py;
    t_flags                       r_s0_flags;
    t_flags                       r_s1_flags;
    t_flags                       r_s2_flags;
    t_edge_sign                   sign_top;
    t_edge_sign                   sign_bottom;
    t_edge_sign                   sign_left;
    t_edge_sign                   sign_right;
    logic                         adv;

    assign adv         = !(o_valid && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    piqf_cfg_regs #(
        .COORD_BITS(COORD_BITS)
    ) u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_corner(corner)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_flags <= '0;
            r_s1_flags <= '0;
            r_s2_flags <= '0;
        end else if (adv) begin
            r_s0_flags <= '{valid: i_valid, keep: i_keep_in, last: i_last};
            r_s1_flags <= r_s0_flags;
            r_s2_flags <= r_s1_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_s0_px <= i_point_x;
            r_s0_py <= i_point_y;
        end
    end

    // Corner k sits at register 2k (x) and 2k+1 (y).
    piqf_edge_eval #(.COORD_BITS(COORD_BITS)) u_edge_top (
        .i_clk(i_clk), .i_en(adv),
        .i_ex(corner[0]), .i_ey(corner[1]), .i_fx(corner[6]), .i_fy(corner[7]),
        .i_px(r_s0_px), .i_py(r_s0_py), .o_sign(sign_top)
    );

    piqf_edge_eval #(.COORD_BITS(COORD_BITS)) u_edge_bottom (
        .i_clk(i_clk), .i_en(adv),
        .i_ex(corner[2]), .i_ey(corner[3]), .i_fx(corner[4]), .i_fy(corner[5]),
        .i_px(r_s0_px), .i_py(r_s0_py), .o_sign(sign_bottom)
    );

    piqf_edge_eval #(.COORD_BITS(COORD_BITS)) u_edge_left (
        .i_clk(i_clk), .i_en(adv),
        .i_ex(corner[0]), .i_ey(corner[1]), .i_fx(corner[2]), .i_fy(corner[3]),
        .i_px(r_s0_px), .i_py(r_s0_py), .o_sign(sign_left)
    );

    piqf_edge_eval #(.COORD_BITS(COORD_BITS)) u_edge_right (
        .i_clk(i_clk), .i_en(adv),
        .i_ex(corner[6]), .i_ey(corner[7]), .i_fx(corner[4]), .i_fy(corner[5]),
        .i_px(r_s0_px), .i_py(r_s0_py), .o_sign(sign_right)
    );

    piqf_count #(
        .COUNT_BITS(COUNT_BITS)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_flags (r_s2_flags),
        .i_top   (sign_top),
        .i_bottom(sign_bottom),
        .i_left  (sign_left),
        .i_right (sign_right),
        .o_valid (o_valid),
        .o_keep  (o_keep_out),
        .o_count (o_inside_count),
        .o_last  (o_last_out)
    );

endmodule

// ----- test/tb_point_in_quad_filter_core.sv -----
`timescale 1ns / 100ps

import piqf_pkg::*;

localparam int COORD_W = 16;
localparam int COUNT_W = 16;

typedef logic signed [COORD_W-1:0] t_coord;
typedef logic [COUNT_W-1:0] t_count;

typedef struct packed {
    logic   keep;
    t_count count;
    logic   last;
} t_point_verdict;

class quad_scoreboard;
    t_coord         corner [NUM_CORNER_REGS];
    t_count         kept_total;
    t_point_verdict expected_q [$];
    int             errors;
    int             checked;
    int             kept;

    function new();
        foreach (corner[i]) corner[i] = '0;
        kept_total = '0;
        errors = 0;
        checked = 0;
        kept = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COORD_W-1:0] data);
        if (idx < NUM_CORNER_REGS) corner[idx[2:0]] = data;
    endfunction

    // Sign of the line through corners e and f, evaluated at the point.
    function int side_of(int e, int f, longint px, longint py);
        longint v;
        v = (longint'(corner[2*f+1]) - corner[2*e+1]) * (px - corner[2*e])
          - (longint'(corner[2*f]) - corner[2*e]) * (py - corner[2*e+1]);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    function void note_point(t_coord x, t_coord y, logic keep, logic last);
        t_point_verdict want;
        want.keep = keep
                 && side_of(0, 3, x, y) * side_of(1, 2, x, y) <= 0
                 && side_of(0, 1, x, y) * side_of(3, 2, x, y) <= 0;
        if (want.keep) begin
            kept++;
            if (kept_total != '1) kept_total++;
        end
        want.count = kept_total;
        want.last = last;
        if (last) kept_total = '0;
        expected_q.insert(expected_q.size(), want);
    endfunction

    function void mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
        errors++;
        if (errors <= 20) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
        end
    endfunction

    function void check_result(logic keep, t_count count, logic last);
        t_point_verdict want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 20) begin
                $display("%0t: word with no point waiting, keep %0b count %0d last %0b",
                         $time, keep, count, last);
            end
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (keep !== want.keep) mismatch("keep_out", want.keep, keep);
        if (count !== want.count) mismatch("inside_count", want.count, count);
        if (last !== want.last) mismatch("last_out", want.last, last);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_point_in_quad_filter_core;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [COORD_W-1:0]        i_point_x;
    logic [COORD_W-1:0]        i_point_y;
    logic                      i_keep_in;
    logic                      i_last;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_keep_out;
    logic [COUNT_W-1:0]        o_inside_count;
    logic                      o_last_out;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [COORD_W-1:0]        i_cfg_data;

    quad_scoreboard board;
    t_coord         quad [NUM_CORNER_REGS];
    bit             quiet;

    point_in_quad_filter_core #(
        .COORD_BITS(COORD_W),
        .COUNT_BITS(COUNT_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_keep_in      (i_keep_in),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_keep_out     (o_keep_out),
        .o_inside_count (o_inside_count),
        .o_last_out     (o_last_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_coord near(int lo, int hi);
        int v;
        v = lo - 32 + int'($urandom_range(hi - lo + 64));
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return t_coord'(v);
    endfunction

    function automatic void set_rect(int l, int t, int r, int b);
        quad[REG_TOP_LEFT_X]     = t_coord'(l);
        quad[REG_TOP_LEFT_Y]     = t_coord'(t);
        quad[REG_BOTTOM_LEFT_X]  = t_coord'(l);
        quad[REG_BOTTOM_LEFT_Y]  = t_coord'(b);
        quad[REG_BOTTOM_RIGHT_X] = t_coord'(r);
        quad[REG_BOTTOM_RIGHT_Y] = t_coord'(b);
        quad[REG_TOP_RIGHT_X]    = t_coord'(r);
        quad[REG_TOP_RIGHT_Y]    = t_coord'(t);
    endfunction

    function automatic void random_rect();
        int l;
        int t;
        l = -int'($urandom_range(400));
        t = -int'($urandom_range(400));
        set_rect(l, t, l + 16 + int'($urandom_range(600)), t + 16 + int'($urandom_range(600)));
    endfunction

    function automatic void jitter_corners(int amount);
        foreach (quad[i]) quad[i] = near(quad[i] - amount, quad[i] + amount);
    endfunction

    task automatic load_corners(input bit stray);
        int n;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [COORD_W-1:0]        data;
        n = stray ? NUM_CORNER_REGS + 1 : NUM_CORNER_REGS;
        for (int i = 0; i < n; i++) begin
            if (i < NUM_CORNER_REGS) begin
                idx = CFG_INDEX_BITS'(i);
                data = quad[i];
            end else begin
                // An index past the corner registers must leave the quad alone.
                idx = CFG_INDEX_BITS'($urandom_range(15, NUM_CORNER_REGS));
                data = COORD_W'($urandom());
            end
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            board.write_reg(idx, data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input t_coord x, input t_coord y, input logic keep,
                              input logic last);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_keep_in <= keep;
        i_last <= last;
        do @(posedge i_clk); while (o_stall);
        board.note_point(x, y, keep, last);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic random_points(input int n);
        int xl;
        int xh;
        int yl;
        int yh;
        t_coord x;
        t_coord y;
        xl = 32767;
        xh = -32768;
        yl = 32767;
        yh = -32768;
        for (int k = 0; k < 4; k++) begin
            if (quad[2*k] < xl) xl = quad[2*k];
            if (quad[2*k] > xh) xh = quad[2*k];
            if (quad[2*k+1] < yl) yl = quad[2*k+1];
            if (quad[2*k+1] > yh) yh = quad[2*k+1];
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                x = t_coord'($urandom());
                y = t_coord'($urandom());
            end else begin
                x = near(xl, xh);
                y = near(yl, yh);
            end
            send_point(x, y, $urandom_range(9) != 0, $urandom_range(29) == 0);
        end
    endtask

    // The receiver stalls at random, and once holds off long enough to back up the pipeline.
    initial begin
        int hold_cycles;
        bit held;
        hold_cycles = 0;
        held = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && !i_stall) begin
                board.check_result(o_keep_out, o_inside_count, o_last_out);
            end
            if (!held && board.checked >= 400) begin
                held = 1;
                hold_cycles = 64;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet && $urandom_range(99) < 6;
            end
        end
    end

    initial begin
        t_coord cx;
        t_coord cy;
        board = new();
        quiet = 0;
        foreach (quad[i]) quad[i] = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_point_x <= '0;
        i_point_y <= '0;
        i_keep_in <= 1'b0;
        i_last <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With all corners at the origin every edge is degenerate and every point passes.
        send_point(0, 0, 1'b1, 1'b0);
        send_point(-32768, 32767, 1'b1, 1'b0);
        send_point(32767, -32768, 1'b0, 1'b1);
        settle();

        set_rect(-800, -800, 800, 800);
        load_corners(1);
        send_point(0, 0, 1'b1, 1'b0);
        send_point(800, 0, 1'b1, 1'b0);
        send_point(-800, -800, 1'b1, 1'b0);
        send_point(800, 800, 1'b1, 1'b0);
        send_point(801, 0, 1'b1, 1'b0);
        send_point(0, -801, 1'b1, 1'b0);
        send_point(0, 800, 1'b1, 1'b0);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(-32768, -32768, 1'b1, 1'b0);
        send_point(32767, 32767, 1'b1, 1'b0);
        send_point(-32768, 0, 1'b1, 1'b0);
        send_point(0, 32767, 1'b1, 1'b0);
        send_point(-1, -1, 1'b1, 1'b0);
        send_point(0, 0, 1'b1, 1'b1);
        send_point(5, 5, 1'b1, 1'b0);
        send_point(0, 0, 1'b0, 1'b1);
        settle();

        set_rect(-32768, -32768, 32767, 32767);
        load_corners(0);
        send_point(-32768, -32768, 1'b1, 1'b0);
        send_point(32767, 32767, 1'b1, 1'b0);
        send_point(-32768, 32767, 1'b1, 1'b0);
        send_point(32767, -32768, 1'b1, 1'b1);
        settle();

        for (int s = 0; s < 6; s++) begin
            case (s)
                0: random_rect();
                1: begin
                    random_rect();
                    jitter_corners(100);
                end
                2: foreach (quad[i]) quad[i] = t_coord'($urandom());
                3: begin
                    // Collapse the top edge so only the left and right edges decide.
                    random_rect();
                    quad[REG_TOP_RIGHT_X] = quad[REG_TOP_LEFT_X];
                    quad[REG_TOP_RIGHT_Y] = quad[REG_TOP_LEFT_Y];
                end
                4: begin
                    random_rect();
                    jitter_corners(60);
                end
                default: set_rect(-32768 + int'($urandom_range(200)),
                                  -32768 + int'($urandom_range(200)),
                                  32767 - int'($urandom_range(200)),
                                  32767 - int'($urandom_range(200)));
            endcase
            load_corners(s % 2);
            quiet = (s == 4);
            random_points(140);
            settle();
            quiet = 0;
        end

        // A quad squeezed to one point makes every edge degenerate.
        cx = t_coord'($urandom());
        cy = t_coord'($urandom());
        set_rect(cx, cy, cx, cy);
        load_corners(0);
        quiet = 1;
        send_point(cx, cy, 1'b0, 1'b0);
        send_point(cx, cy, 1'b1, 1'b1);
        send_point(cx, cy, 1'b1, 1'b0);
        quiet = 0;
        settle();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d words across ten corner settings, %0d points kept.",
                 board.checked, board.kept);
        $display("Covered edges, corners, degenerate quads, rejected points and batch ends.");
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/piqf_pkg.sv
hw/rtl/piqf_cfg_regs.sv
hw/rtl/piqf_edge_eval.sv
hw/rtl/piqf_count.sv
hw/rtl/point_in_quad_filter_core.sv
test/tb_point_in_quad_filter_core.sv
